[hdl/pfes_pkg.sv]
`default_nettype none

package pfes_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FIELD_OFFSET    = 3'd0,
    CFG_FIELD_BYTES     = 3'd1,
    CFG_BIG_ENDIAN      = 3'd2,
    CFG_SIGNED_FIELD    = 3'd3,
    CFG_GAIN            = 3'd4,
    CFG_BIAS            = 3'd5,
    CFG_MIN_INTERVAL_MS = 3'd6
  } cfg_index_t;

  // supported field lengths
  localparam logic [2:0] FIELD_LEN_1 = 3'd1;
  localparam logic [2:0] FIELD_LEN_2 = 3'd2;
  localparam logic [2:0] FIELD_LEN_4 = 3'd4;

  localparam int STORE_DEPTH = 4;
  localparam int RAW_W       = 33;
  localparam int VALUE_W     = 64;

  // register reset values
  localparam logic [2:0]         FIELD_BYTES_RST  = 3'd2;
  localparam logic signed [31:0] GAIN_RST         = 32'sd65536;
  localparam logic [15:0]        MIN_INTERVAL_RST = 16'd100;

  // raw field word handed to the scaling pipeline
  typedef struct packed {
    logic                    valid;
    logic signed [RAW_W-1:0] raw;
  } raw_word_t;

endpackage

`default_nettype wire

[hdl/pfes_scale.sv]
`default_nettype none

module pfes_scale
  import pfes_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire raw_word_t                 raw_in,
  output logic                           in_ready,
  input  wire logic signed [31:0]        gain,
  input  wire logic signed [31:0]        bias,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [VALUE_W-1:0]      out_value
);

  logic                      v1;
  logic signed [RAW_W-1:0]   raw1;
  logic                      v2;
  logic signed [VALUE_W-1:0] prod2;
  logic                      v3;
  logic signed [VALUE_W-1:0] value3;

  logic ready1, ready2, ready3;
  logic signed [RAW_W+31:0]  prod_full;
  logic signed [VALUE_W:0]   sum;
  logic signed [VALUE_W-1:0] sat_value;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // |raw| < 2^32 and |gain| <= 2^31, so the product fits 64 bits
  assign prod_full = raw1 * gain;

  always_comb begin
    sum = {prod2[VALUE_W-1], prod2} + {{(VALUE_W-31){bias[31]}}, bias};
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      sat_value = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      sat_value = sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= raw_in.valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && raw_in.valid) begin
      raw1 <= raw_in.raw;
    end
    if (ready2 && v1) begin
      prod2 <= prod_full[VALUE_W-1:0];
    end
    if (ready3 && v2) begin
      value3 <= sat_value;
    end
  end

  assign out_valid = v3;
  assign out_value = value3;

  a_raw_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !ready2) |=> (v1 && $stable(raw1)))
    else $error("raw stage lost its word under stall");

  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !ready3) |=> (v2 && $stable(prod2)))
    else $error("product stage lost its word under stall");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(v3) |-> $past(v2))
    else $error("output word appeared without a product");

endmodule

`default_nettype wire

[hdl/payload_field_extract_scale.sv]
// path: a reporting last byte is loaded into the raw register at acceptance, then passes
//   the product register and the saturated-add output register that drives m_axis_tvalid
// throughput: one payload byte per cycle; the three-stage scaling pipeline with
//   per-stage ready fills bubbles, so the input only stalls when all stages are full
//   and m_axis_tready is low
// reset: synchronous active-high rst clears byte count, field store, last report
//   time and pipeline valids, and loads the register defaults
`default_nettype none

module payload_field_extract_scale
  import pfes_pkg::*;
#(
  parameter int MAX_PAYLOAD = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // payload stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [7:0] payload_byte, [39:8] now_ms
  input  wire logic        s_axis_tlast,   // last_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [63:0] scaled_value
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int LW = (CW > 10) ? CW : 10;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PAYLOAD);

  // configuration registers
  logic [8:0]         field_offset;
  logic [2:0]         field_bytes;
  logic               big_endian;
  logic               signed_field;
  logic signed [31:0] gain;
  logic signed [31:0] bias;
  logic [15:0]        min_interval_ms;

  // packet state
  logic [CW-1:0] byte_count;
  logic [7:0]    field_store [STORE_DEPTH];
  logic [31:0]   last_report_ms;

  logic [7:0]    payload_byte;
  logic [31:0]   now_ms;
  logic          accept;
  logic          count_room;
  logic [CW-1:0] count_inc;
  logic [LW-1:0] pos;
  logic [LW-1:0] rel;
  logic          capture;
  logic [7:0]    store_next [STORE_DEPTH];
  logic          len_ok;
  logic [31:0]   gap;
  logic          time_ok;
  logic          fire;
  logic [7:0]    hi_byte, lo_byte;
  logic [31:0]   word4;
  logic signed [RAW_W-1:0] raw;
  raw_word_t     raw_word;
  logic          scale_ready;
  logic signed [VALUE_W-1:0] scaled_value;

  assign payload_byte  = s_axis_tdata[7:0];
  assign now_ms        = s_axis_tdata[39:8];
  assign s_axis_tready = scale_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // byte position and capture window
  assign count_room = byte_count < COUNT_MAX;
  assign count_inc  = count_room ? byte_count + CW'(1) : byte_count;
  assign pos        = LW'(byte_count);
  assign rel        = pos - LW'(field_offset);
  assign capture    = accept && count_room && (pos >= LW'(field_offset))
                      && (rel < LW'(field_bytes)) && (rel < LW'(STORE_DEPTH));

  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      store_next[k] = field_store[k];
    end
    if (capture) begin
      store_next[rel[1:0]] = payload_byte;
    end
  end

  // report decision, length counts the last byte itself
  assign len_ok  = LW'(count_inc) >= (LW'(field_offset) + LW'(field_bytes));
  assign gap     = now_ms - last_report_ms;
  assign time_ok = gap >= {16'b0, min_interval_ms};
  assign fire    = accept && s_axis_tlast && len_ok && time_ok;

  // raw field from the store including this byte
  always_comb begin
    hi_byte = big_endian ? store_next[0] : store_next[1];
    lo_byte = big_endian ? store_next[1] : store_next[0];
    word4   = big_endian
              ? {store_next[0], store_next[1], store_next[2], store_next[3]}
              : {store_next[3], store_next[2], store_next[1], store_next[0]};
    case (field_bytes)
      FIELD_LEN_1: raw = {{(RAW_W-8){signed_field & store_next[0][7]}}, store_next[0]};
      FIELD_LEN_2: raw = {{(RAW_W-16){signed_field & hi_byte[7]}}, hi_byte, lo_byte};
      FIELD_LEN_4: raw = {{(RAW_W-32){signed_field & word4[31]}}, word4};
      default:     raw = '0;
    endcase
  end

  assign raw_word.valid = fire;
  assign raw_word.raw   = raw;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_offset    <= '0;
      field_bytes     <= FIELD_BYTES_RST;
      big_endian      <= 1'b0;
      signed_field    <= 1'b0;
      gain            <= GAIN_RST;
      bias            <= '0;
      min_interval_ms <= MIN_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIELD_OFFSET:    field_offset    <= cfg_data[8:0];
        CFG_FIELD_BYTES:     field_bytes     <= cfg_data[2:0];
        CFG_BIG_ENDIAN:      big_endian      <= cfg_data[0];
        CFG_SIGNED_FIELD:    signed_field    <= cfg_data[0];
        CFG_GAIN:            gain            <= cfg_data;
        CFG_BIAS:            bias            <= cfg_data;
        CFG_MIN_INTERVAL_MS: min_interval_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // packet state, count returns to zero after every last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      last_report_ms <= '0;
      for (int k = 0; k < STORE_DEPTH; k++) begin
        field_store[k] <= '0;
      end
    end else begin
      if (accept) begin
        byte_count <= s_axis_tlast ? '0 : count_inc;
      end
      for (int k = 0; k < STORE_DEPTH; k++) begin
        field_store[k] <= store_next[k];
      end
      if (fire) begin
        last_report_ms <= now_ms;
      end
    end
  end

  // multiply, bias add and saturation
  pfes_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .raw_in    (raw_word),
    .in_ready  (scale_ready),
    .gain      (gain),
    .bias      (bias),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (scaled_value)
  );

  assign m_axis_tdata = scaled_value;

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_MAX)
    else $error("byte count beyond payload cap");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (byte_count == '0))
    else $error("byte count not cleared after last byte");

  a_report_time: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(last_report_ms))
    else $error("report time changed without a report");

endmodule

`default_nettype wire

[test/field_scale_checker.sv]
`timescale 1ns / 1ps

module field_scale_checker
  import pfes_pkg::*;
#(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          errors,
  output int          pending
);

  // register copies
  logic [8:0]         field_pos;
  logic [2:0]         field_len;
  logic               msb_first;
  logic               sign_ext;
  logic signed [31:0] gain;
  logic signed [31:0] bias;
  logic [15:0]        gap_ms;

  // packet state
  int unsigned        byte_cnt;
  logic [7:0]         field_q [STORE_DEPTH];
  logic [31:0]        last_report;

  logic signed [63:0] value_q [$];
  int                 shown;

  function automatic logic signed [63:0] field_raw();
    logic [31:0] acc;
    int          idx;
    int          k;
    acc = '0;
    if (field_len != FIELD_LEN_1 && field_len != FIELD_LEN_2 && field_len != FIELD_LEN_4)
      return '0;
    for (k = 0; k < field_len; k++) begin
      idx = msb_first ? k : field_len - 1 - k;
      acc = {acc[23:0], field_q[idx]};
    end
    if (!sign_ext)
      return {32'd0, acc};
    case (field_len)
      FIELD_LEN_1: return {{56{acc[7]}}, acc[7:0]};
      FIELD_LEN_2: return {{48{acc[15]}}, acc[15:0]};
      default:     return {{32{acc[31]}}, acc};
    endcase
  endfunction

  // raw * gain + bias, clamped to the signed 64-bit range
  function automatic logic signed [63:0] scaled(input logic signed [63:0] raw);
    logic signed [63:0] prod;
    logic signed [64:0] sum;
    prod = raw * gain;
    sum  = prod + bias;
    if (sum[64] != sum[63])
      return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return sum[63:0];
  endfunction

  always @(posedge clk) begin
    logic [7:0]         b;
    logic [31:0]        stamp;
    logic signed [63:0] want;
    int unsigned        rel;
    if (rst) begin
      field_pos   = '0;
      field_len   = FIELD_BYTES_RST;
      msb_first   = 1'b0;
      sign_ext    = 1'b0;
      gain        = GAIN_RST;
      bias        = '0;
      gap_ms      = MIN_INTERVAL_RST;
      byte_cnt    = 0;
      last_report = '0;
      for (int i = 0; i < STORE_DEPTH; i++)
        field_q[i] = '0;
      value_q.delete();
    end else begin
      // result side
      if (m_axis_tvalid && m_axis_tready) begin
        if (value_q.size() == 0) begin
          errors++;
          if (shown < 10)
            $display("%0t: unexpected word %h", $realtime, m_axis_tdata);
          shown++;
        end else begin
          want = value_q.pop_front();
          if (m_axis_tdata !== want) begin
            errors++;
            if (shown < 10)
              $display("%0t: scaled_value mismatch, expected %h, got %h",
                       $realtime, want, m_axis_tdata);
            shown++;
          end
        end
      end

      // payload side, against the registers as they stand before this edge
      if (s_axis_tvalid && s_axis_tready) begin
        b     = s_axis_tdata[7:0];
        stamp = s_axis_tdata[39:8];
        if (byte_cnt < MAX_PAYLOAD) begin
          if (byte_cnt >= field_pos) begin
            rel = byte_cnt - field_pos;
            if (rel < field_len && rel < STORE_DEPTH)
              field_q[rel] = b;
          end
          byte_cnt++;
        end
        if (s_axis_tlast) begin
          if (byte_cnt >= field_pos + field_len && (stamp - last_report) >= gap_ms) begin
            value_q = {value_q, scaled(field_raw())};
            last_report = stamp;
          end
          byte_cnt = 0;
        end
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FIELD_OFFSET:    field_pos = cfg_data[8:0];
          CFG_FIELD_BYTES:     field_len = cfg_data[2:0];
          CFG_BIG_ENDIAN:      msb_first = cfg_data[0];
          CFG_SIGNED_FIELD:    sign_ext  = cfg_data[0];
          CFG_GAIN:            gain      = cfg_data;
          CFG_BIAS:            bias      = cfg_data;
          CFG_MIN_INTERVAL_MS: gap_ms    = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    pending = value_q.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pfes_pkg::*;

  localparam int MAX_PAYLOAD = 512;
  // a reporting last byte passes the raw, product and output registers before it leaves the block
  localparam int LATENCY     = 3;

  // one full register set, written as a unit
  typedef struct packed {
    logic [8:0]  field_pos;
    logic [2:0]  field_len;
    logic        msb_first;
    logic        sign_ext;
    logic [31:0] gain;
    logic [31:0] bias;
    logic [15:0] gap_ms;
  } setting_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  wire logic   s_axis_tready;
  logic [39:0] s_axis_tdata;   // [7:0] payload_byte, [39:8] now_ms
  logic        s_axis_tlast;   // last_byte
  wire logic   m_axis_tvalid;
  logic        m_axis_tready;
  wire logic [63:0] m_axis_tdata;  // [63:0] scaled_value

  int          errors;
  int          pending;

  // percentages of cycles in which the sender idles and the receiver stalls
  int          src_idle_pct;
  int          sink_stall_pct;

  // running millisecond clock used for last bytes of random packets
  logic [31:0] clock_ms;
  setting_t    cur;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  payload_field_extract_scale #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  field_scale_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .pending      (pending)
  );

  // receiver: a fresh ready decision every cycle
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // all tasks that wait on the clock start and end right after a falling edge

  // walk through every register; enable stays high across the burst
  task automatic apply_setting(input setting_t s);
    cur = s;
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FIELD_OFFSET;
    cfg_data  <= 32'(s.field_pos);
    @(negedge clk);
    cfg_index <= CFG_FIELD_BYTES;
    cfg_data  <= 32'(s.field_len);
    @(negedge clk);
    cfg_index <= CFG_BIG_ENDIAN;
    cfg_data  <= 32'(s.msb_first);
    @(negedge clk);
    cfg_index <= CFG_SIGNED_FIELD;
    cfg_data  <= 32'(s.sign_ext);
    @(negedge clk);
    cfg_index <= CFG_GAIN;
    cfg_data  <= s.gain;
    @(negedge clk);
    cfg_index <= CFG_BIAS;
    cfg_data  <= s.bias;
    @(negedge clk);
    cfg_index <= CFG_MIN_INTERVAL_MS;
    cfg_data  <= 32'(s.gap_ms);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one payload word, with random idle cycles ahead of it
  task automatic send_word(input logic [7:0] b, input logic last, input logic [31:0] stamp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {stamp, b};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // stop sending, let every expected word drain, then cover the pipeline depth
  // in case the last packet gave nothing
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
      default: begin src_idle_pct = 22; sink_stall_pct = 22; end
    endcase
  endtask

  // payload bytes lean toward the sign and range corners
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // gain and bias values, extremes included
  function automatic logic [31:0] pick_word();
    case ($urandom_range(6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4: return 32'hffff_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic setting_t random_setting();
    setting_t s;
    s.field_pos = ($urandom_range(5) == 0) ? 9'($urandom_range(4, 12))
                                           : 9'($urandom_range(0, 3));
    case ($urandom_range(9))
      0: s.field_len = 3'd0;
      1: s.field_len = 3'd3;
      2: s.field_len = 3'($urandom_range(5, 7));   // out of range, raw reads as zero
      3, 4: s.field_len = FIELD_LEN_1;
      5, 6: s.field_len = FIELD_LEN_2;
      default: s.field_len = FIELD_LEN_4;
    endcase
    s.msb_first = 1'($urandom);
    s.sign_ext  = 1'($urandom);
    s.gain      = pick_word();
    s.bias      = pick_word();
    case ($urandom_range(7))
      0: s.gap_ms = 16'd0;
      1: s.gap_ms = 16'hffff;
      default: s.gap_ms = 16'($urandom_range(1, 200));
    endcase
    return s;
  endfunction

  // advance the clock mostly past the minimum interval, sometimes short of it,
  // sometimes by a random jump that may wrap
  function automatic logic [31:0] next_stamp();
    case ($urandom_range(9))
      7: clock_ms = clock_ms + $urandom_range(0, cur.gap_ms);
      8: clock_ms = clock_ms + $urandom;
      9: clock_ms = clock_ms + cur.gap_ms - 1;
      default: clock_ms = clock_ms + cur.gap_ms + $urandom_range(0, 40);
    endcase
    return clock_ms;
  endfunction

  // only the last word's stamp matters; the others carry noise
  task automatic send_packet(input int len, input logic [31:0] stamp);
    for (int i = 0; i < len; i++)
      send_word(pick_byte(), i == len - 1, (i == len - 1) ? stamp : $urandom);
  endtask

  initial begin
    setting_t s;
    int       need;
    int       pkt_len;
    int       phase_items;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_FIELD_OFFSET;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    clock_ms      = '0;
    set_idle(0);
    cur = '{field_pos: '0, field_len: FIELD_BYTES_RST, msb_first: 1'b0, sign_ext: 1'b0,
            gain: GAIN_RST, bias: '0, gap_ms: MIN_INTERVAL_RST};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed words on the reset settings: 2 bytes, little endian, unsigned
    // widest unsigned field, interval exactly at the minimum
    send_word(8'hff, 1'b0, 32'hffff_ffff);
    send_word(8'hff, 1'b1, 32'd100);
    // packet too short for the field
    send_word(8'h5a, 1'b1, 32'd900);
    // stamp behind the last report: the wrapped difference is huge, so it reports
    send_word(8'h00, 1'b0, 32'd0);
    send_word(8'h80, 1'b1, 32'd99);
    // one millisecond short of the interval
    send_word(8'h01, 1'b0, 32'd0);
    send_word(8'h02, 1'b1, 32'd198);
    quiesce();

    // 4 bytes at offset 1, big endian, signed, largest gain and bias, no interval
    apply_setting('{field_pos: 9'd1, field_len: FIELD_LEN_4, msb_first: 1'b1, sign_ext: 1'b1,
                    gain: 32'h7fff_ffff, bias: 32'h7fff_ffff, gap_ms: 16'd0});
    send_word(8'h00, 1'b0, 32'd0);
    send_word(8'h80, 1'b0, 32'd0);
    send_word(8'h00, 1'b0, 32'd0);
    send_word(8'h00, 1'b0, 32'd0);
    send_word(8'h00, 1'b1, 32'd198);   // 99 ms after the last report
    quiesce();

    // 1 signed byte, most negative gain and bias, longest interval
    apply_setting('{field_pos: 9'd0, field_len: FIELD_LEN_1, msb_first: 1'b0, sign_ext: 1'b1,
                    gain: 32'h8000_0000, bias: 32'h8000_0000, gap_ms: 16'hffff});
    send_word(8'h80, 1'b1, 32'd198 + 32'd65535);
    send_word(8'hff, 1'b1, 32'd198 + 32'd65535 + 32'd65534);
    quiesce();

    // unsupported length: the value is the bias alone, sign setting ignored
    apply_setting('{field_pos: 9'd0, field_len: 3'd3, msb_first: 1'b0, sign_ext: 1'b1,
                    gain: 32'h0001_0000, bias: 32'h0000_3039, gap_ms: 16'd0});
    send_packet(3, 32'd5);
    quiesce();
    apply_setting('{field_pos: 9'd0, field_len: 3'd7, msb_first: 1'b1, sign_ext: 1'b0,
                    gain: 32'hffff_0000, bias: 32'hffff_cfc7, gap_ms: 16'd0});
    send_packet(7, 32'd6);
    quiesce();

    // settings changed mid-packet: the second field byte is left over from before
    apply_setting('{field_pos: 9'd0, field_len: FIELD_LEN_1, msb_first: 1'b0, sign_ext: 1'b0,
                    gain: 32'h0001_0000, bias: 32'h0, gap_ms: 16'd0});
    send_word(8'ha5, 1'b0, 32'd0);
    send_word(8'h3c, 1'b0, 32'd0);
    quiesce();
    s = cur;
    s.field_len = FIELD_LEN_2;
    s.msb_first = 1'b1;
    apply_setting(s);
    send_word(8'hc3, 1'b1, 32'd7);
    quiesce();

    // --- random phases: mostly packets that fit the field, some short or odd
    clock_ms = $urandom;
    for (int p = 0; p < 12; p++) begin
      set_idle(p % 4);
      apply_setting(random_setting());
      phase_items = 0;
      while (phase_items < 10) begin
        need = cur.field_pos + cur.field_len;
        case ($urandom_range(9))
          7: pkt_len = (need > 1) ? $urandom_range(1, need - 1) : 1;
          8: pkt_len = $urandom_range(1, 16);
          default: pkt_len = need + $urandom_range(0, 3);
        endcase
        if (pkt_len < 1)
          pkt_len = 1;
        send_packet(pkt_len, next_stamp());
        phase_items += pkt_len;
      end
      quiesce();
    end

    // --- field on the last two bytes of the largest payload, extra bytes dropped
    set_idle(3);
    s = random_setting();
    s.field_pos = 9'd510;
    s.field_len = FIELD_LEN_2;
    s.gap_ms    = 16'd0;
    apply_setting(s);
    send_packet(MAX_PAYLOAD + 4, $urandom);
    quiesce();

    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[payload_field_extract_scale.f]
hdl/pfes_pkg.sv
hdl/pfes_scale.sv
hdl/payload_field_extract_scale.sv
test/field_scale_checker.sv
test/tb.sv
